/* rtl/core/dbvsg_pkg.sv */
// Types, register indexes and charge curve tables for the dual battery gauge.
package dbvsg_pkg;

  localparam int CURVE_POINTS = 11;
  localparam int SEG_W        = 4;
  localparam int OFFS_W       = 11;
  localparam int SLOPE_W      = 21;
  localparam int CHARGE_W     = 14;
  localparam int GAIN_W       = 16;
  localparam int TAP_W        = 12;
  localparam int MV_W         = 16;
  localparam int FRAC_BITS    = 12;
  localparam int SLOPE_FRAC   = 16;

  localparam logic [SEG_W-1:0]    SEG_TOP     = 4'd10;
  localparam logic [CHARGE_W-1:0] CHARGE_FULL = 14'd10000;
  localparam logic signed [17:0]  MV_FLOOR    = 18'sd10000;
  localparam logic signed [17:0]  MV_CEIL     = 18'sd13600;

  typedef enum logic [0:0] {
    REG_LOWER_GAIN = 1'b0,
    REG_STACK_GAIN = 1'b1
  } reg_idx_t;

  localparam logic signed [17:0] CURVE_MV [CURVE_POINTS] = '{
    18'sd10000, 18'sd12000, 18'sd12500, 18'sd12800, 18'sd12900, 18'sd13000,
    18'sd13100, 18'sd13200, 18'sd13300, 18'sd13400, 18'sd13600
  };

  localparam logic [CHARGE_W-1:0] CURVE_CHARGE [CURVE_POINTS] = '{
    14'd0, 14'd900, 14'd1400, 14'd1700, 14'd2000, 14'd3000,
    14'd4000, 14'd7000, 14'd9000, 14'd9900, 14'd10000
  };

  // slope of each segment in Q.16, rounded up; zero above the top point
  localparam logic [SLOPE_W-1:0] CURVE_SLOPE [CURVE_POINTS] = '{
    21'd29492, 21'd65536, 21'd65536, 21'd196608, 21'd655360, 21'd655360,
    21'd1966080, 21'd1310720, 21'd589824, 21'd32768, 21'd0
  };

  typedef struct packed {
    logic [TAP_W-1:0] lower_tap_mv;
    logic [TAP_W-1:0] upper_tap_mv;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0]  upper_battery_mv;
    logic [MV_W-1:0]     lower_battery_mv;
    logic [CHARGE_W-1:0] upper_battery_charge;
    logic [CHARGE_W-1:0] lower_battery_charge;
  } out_item_t;

  typedef struct packed {
    logic [SEG_W-1:0]  idx;
    logic [OFFS_W-1:0] offs;
  } seg_t;

endpackage

/* rtl/core/dual_battery_voltage_soc_gauge.sv */
// Four-stage pipeline: tap scaling, stack subtraction, segment search, interpolation.
//
//   channel   ports                              transfer
//   input     start, busy, in_data               start && !busy at a rising edge
//   result    out_valid, out_data                out_valid for one cycle
//   config    cfg_we, cfg_index, cfg_wdata       cfg_we at a rising edge
//
// One pair enters per cycle; its result shows once it has passed all four register stages.
// The four register stages are: multiply, subtract, compare, multiply-add.
// busy stays low; the receiver takes every result as it appears.
// Reset restores the default gains and drops all items in flight.
module dual_battery_voltage_soc_gauge
  import dbvsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_item_t            in_data,
  output logic                out_valid,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [GAIN_W-1:0]   cfg_wdata
);

  logic [GAIN_W-1:0] lower_gain_r, lower_gain_nxt;
  logic [GAIN_W-1:0] stack_gain_r, stack_gain_nxt;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic [MV_W-1:0] lower_mv1_r, stack_mv1_r;
  logic [MV_W-1:0] lower_mv2_r;
  logic signed [16:0] upper_mv2_r;
  logic [MV_W-1:0] lower_mv3_r;
  logic signed [16:0] upper_mv3_r;
  seg_t upper_seg3_r, lower_seg3_r;
  out_item_t out_data_r;

  logic [TAP_W+GAIN_W-1:0] lower_prod, stack_prod;
  logic signed [17:0] upper_ext, lower_ext;
  seg_t upper_seg, lower_seg;
  logic [OFFS_W+SLOPE_W-1:0] upper_ip, lower_ip;
  logic accept;

  function automatic seg_t locate(input logic signed [17:0] mv);
    seg_t res;
    logic [SEG_W-1:0] cnt;
    logic signed [17:0] diff;
    cnt = '0;
    for (int i = 1; i < CURVE_POINTS - 1; i++) begin
      if (mv > CURVE_MV[i]) cnt = cnt + 4'd1;
    end
    diff = mv - CURVE_MV[cnt];
    if (mv <= MV_FLOOR) begin
      res.idx  = '0;
      res.offs = '0;
    end else if (mv >= MV_CEIL) begin
      res.idx  = SEG_TOP;
      res.offs = '0;
    end else begin
      res.idx  = cnt;
      res.offs = diff[OFFS_W-1:0];
    end
    return res;
  endfunction

  assign accept = start && !busy;
  assign busy   = 1'b0;

  always_comb begin
    lower_gain_nxt = lower_gain_r;
    stack_gain_nxt = stack_gain_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOWER_GAIN: lower_gain_nxt = cfg_wdata;
        REG_STACK_GAIN: stack_gain_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign lower_prod = TAP_W'(in_data.lower_tap_mv) * (TAP_W+GAIN_W)'(lower_gain_r);
  assign stack_prod = TAP_W'(in_data.upper_tap_mv) * (TAP_W+GAIN_W)'(stack_gain_r);

  assign upper_ext = {upper_mv2_r[16], upper_mv2_r};
  assign lower_ext = {2'b00, lower_mv2_r};
  assign upper_seg = locate(upper_ext);
  assign lower_seg = locate(lower_ext);

  assign upper_ip = (OFFS_W+SLOPE_W)'(upper_seg3_r.offs) * CURVE_SLOPE[upper_seg3_r.idx];
  assign lower_ip = (OFFS_W+SLOPE_W)'(lower_seg3_r.offs) * CURVE_SLOPE[lower_seg3_r.idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_gain_r <= 16'd20480;
      stack_gain_r <= 16'd38229;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      lower_gain_r <= lower_gain_nxt;
      stack_gain_r <= stack_gain_nxt;
      v1_r         <= accept;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      out_valid_r  <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    lower_mv1_r  <= lower_prod[FRAC_BITS +: MV_W];
    stack_mv1_r  <= stack_prod[FRAC_BITS +: MV_W];
    lower_mv2_r  <= lower_mv1_r;
    upper_mv2_r  <= signed'({1'b0, stack_mv1_r}) - signed'({1'b0, lower_mv1_r});
    lower_mv3_r  <= lower_mv2_r;
    upper_mv3_r  <= upper_mv2_r;
    upper_seg3_r <= upper_seg;
    lower_seg3_r <= lower_seg;
    out_data_r.upper_battery_mv     <= upper_mv3_r;
    out_data_r.lower_battery_mv     <= lower_mv3_r;
    out_data_r.upper_battery_charge <= CHARGE_W'(CURVE_CHARGE[upper_seg3_r.idx]
                                       + upper_ip[SLOPE_FRAC +: CHARGE_W]);
    out_data_r.lower_battery_charge <= CHARGE_W'(CURVE_CHARGE[lower_seg3_r.idx]
                                       + lower_ip[SLOPE_FRAC +: CHARGE_W]);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/dbvsg_checker.sv */
// Port-level checker for the dual battery gauge, with its bind.
module dbvsg_assertions
  import dbvsg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 4))
    else $error("result without a matching input transfer");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && !busy && rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2)
     && $past(rst_n, 1)) |-> out_valid)
    else $error("input transfer produced no result");

  a_charge_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.upper_battery_charge <= CHARGE_FULL)
                  && (out_data.lower_battery_charge <= CHARGE_FULL))
    else $error("charge above full scale");

  a_upper_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.upper_battery_mv <= 17'sd10000))
      |-> (out_data.upper_battery_charge == '0))
    else $error("upper charge not zero at or below curve bottom");

  a_lower_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.lower_battery_mv >= 16'd13600))
      |-> (out_data.lower_battery_charge == CHARGE_FULL))
    else $error("lower charge not full at or above curve top");

endmodule

bind dual_battery_voltage_soc_gauge dbvsg_assertions u_dbvsg_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
